// ===== src/assert_macros.svh =====
// Assertion macros shared by the switch encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ORS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ORS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ORS_ASSERT(label, clk, rst, prop)
`define ORS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== src/ors_pkg.sv =====
// Shared types, register indexes and reset values for the switch encoder.
`timescale 1ns / 1ps
`default_nettype none
package ors_pkg;

  localparam int unsigned SenderW = 26;
  localparam int unsigned SwitchW = 4;
  localparam int unsigned SegW    = 14;
  localparam int unsigned GapW    = 16;
  localparam int unsigned RepW    = 4;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] CFG_PULSE_HIGH   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_LOW     = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_LOW    = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_HIGH    = 8'd3;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_LATCH  = 8'd4;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_LATCH = 8'd5;
  localparam logic [CfgIdxW-1:0] CFG_GAP          = 8'd6;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT       = 8'd7;

  localparam logic [SegW-1:0] RST_PULSE_HIGH   = 14'd310;
  localparam logic [SegW-1:0] RST_LONG_LOW     = 14'd1340;
  localparam logic [SegW-1:0] RST_SHORT_LOW    = 14'd310;
  localparam logic [SegW-1:0] RST_SYNC_HIGH    = 14'd275;
  localparam logic [SegW-1:0] RST_FIRST_LATCH  = 14'd9900;
  localparam logic [SegW-1:0] RST_SECOND_LATCH = 14'd2675;
  localparam logic [GapW-1:0] RST_GAP          = 16'd10000;
  localparam logic [RepW-1:0] RST_REPEAT       = 4'd5;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef struct packed {
    logic [SegW-1:0] pulse_high_ticks;
    logic [SegW-1:0] long_low_ticks;
    logic [SegW-1:0] short_low_ticks;
    logic [SegW-1:0] sync_high_ticks;
    logic [SegW-1:0] first_latch_ticks;
    logic [SegW-1:0] second_latch_ticks;
    logic [GapW-1:0] gap_ticks;
    logic [RepW-1:0] repeat_count;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [SenderW-1:0] sender_id;
    logic [SwitchW-1:0] switch_code;
    logic               turn_on;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic start_ignored;
  } result_t;

endpackage
`default_nettype wire

// ===== src/ors_if.sv =====
// Handshake channels of the switch encoder: input items, result items, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface ors_item_if;
  import ors_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SenderW-1:0] sender_id;
  logic [SwitchW-1:0] switch_code;
  logic               turn_on;
  modport source (output valid, mode, sender_id, switch_code, turn_on, input ready);
  modport sink   (input valid, mode, sender_id, switch_code, turn_on, output ready);
endinterface

interface ors_result_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic start_ignored;
  modport source (output valid, pin_level, busy_res, start_ignored, input ready);
  modport sink   (input valid, pin_level, busy_res, start_ignored, output ready);
endinterface

interface ors_cfg_if;
  import ors_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/ors_cfg_regs.sv =====
// Timing and repeat registers of the switch encoder.
`timescale 1ns / 1ps
`default_nettype none
module ors_cfg_regs
  import ors_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  ors_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pulse_high_ticks   <= RST_PULSE_HIGH;
      regs.long_low_ticks     <= RST_LONG_LOW;
      regs.short_low_ticks    <= RST_SHORT_LOW;
      regs.sync_high_ticks    <= RST_SYNC_HIGH;
      regs.first_latch_ticks  <= RST_FIRST_LATCH;
      regs.second_latch_ticks <= RST_SECOND_LATCH;
      regs.gap_ticks          <= RST_GAP;
      regs.repeat_count       <= RST_REPEAT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_PULSE_HIGH:   regs.pulse_high_ticks   <= cfg.data[SegW-1:0];
        CFG_LONG_LOW:     regs.long_low_ticks     <= cfg.data[SegW-1:0];
        CFG_SHORT_LOW:    regs.short_low_ticks    <= cfg.data[SegW-1:0];
        CFG_SYNC_HIGH:    regs.sync_high_ticks    <= cfg.data[SegW-1:0];
        CFG_FIRST_LATCH:  regs.first_latch_ticks  <= cfg.data[SegW-1:0];
        CFG_SECOND_LATCH: regs.second_latch_ticks <= cfg.data[SegW-1:0];
        CFG_GAP:          regs.gap_ticks          <= cfg.data[GapW-1:0];
        CFG_REPEAT:       regs.repeat_count       <= cfg.data[RepW-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/ors_frame_core.sv =====
// Frame sequencer: segment timer, bit walker and frame repeat counter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ors_frame_core
  import ors_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    regs,
  input  wire logic    step,
  input  wire item_t   item,
  output result_t      res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SYNC, PH_LATCH, PH_DATA_HI, PH_DATA_LO, PH_CLOSE, PH_GAP
  } phase_t;

  localparam logic [4:0] LastBit = 5'd31;

  phase_t             phase, phase_next;
  logic [RepW-1:0]    frames_left, frames_left_next;
  logic [4:0]         bit_position, bit_position_next;
  logic               pair_half, pair_half_next;
  logic [GapW-1:0]    tick_count, tick_count_next;
  logic [SenderW-1:0] held_sender, held_sender_next;
  logic [SwitchW-1:0] held_switch, held_switch_next;
  logic               held_on, held_on_next;
  logic               line_level, line_level_next;

  logic [31:0]     frame_word;
  logic            pulse_val;
  logic [GapW-1:0] seg_len;
  logic            seg_level;
  logic            seg_end;

  // logical bit, MSB first, flipped on the second half of the pair
  assign frame_word = {held_sender, 1'b0, held_on, held_switch};
  assign pulse_val  = frame_word[LastBit - bit_position] ^ pair_half;

  always_comb begin
    case (phase)
      PH_SYNC:    seg_len = GapW'(regs.sync_high_ticks);
      PH_LATCH:   seg_len = pair_half ? GapW'(regs.second_latch_ticks)
                                      : GapW'(regs.first_latch_ticks);
      PH_DATA_HI: seg_len = GapW'(regs.pulse_high_ticks);
      PH_DATA_LO: seg_len = pulse_val ? GapW'(regs.long_low_ticks)
                                      : GapW'(regs.short_low_ticks);
      PH_CLOSE:   seg_len = GapW'(regs.sync_high_ticks);
      PH_GAP:     seg_len = regs.gap_ticks;
      default:    seg_len = GapW'(1);
    endcase
  end

  assign seg_level = (phase == PH_SYNC) || (phase == PH_DATA_HI) || (phase == PH_CLOSE);
  // zero length behaves as one tick
  assign seg_end   = ({1'b0, tick_count} + 17'd1) >= {1'b0, seg_len};

  always_comb begin
    phase_next        = phase;
    frames_left_next  = frames_left;
    bit_position_next = bit_position;
    pair_half_next    = pair_half;
    tick_count_next   = tick_count;
    held_sender_next  = held_sender;
    held_switch_next  = held_switch;
    held_on_next      = held_on;
    line_level_next   = line_level;
    res.start_ignored = 1'b0;
    res.pin_level     = 1'b0;

    if (item.mode == MODE_START) begin
      res.pin_level = line_level;
      if (phase != PH_IDLE) begin
        res.start_ignored = 1'b1;
      end else begin
        held_sender_next  = item.sender_id;
        held_switch_next  = item.switch_code;
        held_on_next      = item.turn_on;
        frames_left_next  = (regs.repeat_count != '0) ? regs.repeat_count : RepW'(1);
        bit_position_next = '0;
        pair_half_next    = 1'b0;
        tick_count_next   = '0;
        phase_next        = PH_SYNC;
      end
    end else if (phase == PH_IDLE) begin
      line_level_next = 1'b0;
    end else begin
      res.pin_level   = seg_level;
      line_level_next = seg_level;
      if (!seg_end) begin
        tick_count_next = tick_count + GapW'(1);
      end else begin
        tick_count_next = '0;
        case (phase)
          PH_SYNC: phase_next = PH_LATCH;
          PH_LATCH: begin
            if (!pair_half) begin
              phase_next     = PH_SYNC;
              pair_half_next = 1'b1;
            end else begin
              phase_next        = PH_DATA_HI;
              pair_half_next    = 1'b0;
              bit_position_next = '0;
            end
          end
          PH_DATA_HI: phase_next = PH_DATA_LO;
          PH_DATA_LO: begin
            if (!pair_half) begin
              pair_half_next = 1'b1;
              phase_next     = PH_DATA_HI;
            end else begin
              pair_half_next = 1'b0;
              if (bit_position == LastBit) begin
                phase_next = PH_CLOSE;
              end else begin
                bit_position_next = bit_position + 5'd1;
                phase_next        = PH_DATA_HI;
              end
            end
          end
          PH_CLOSE: phase_next = PH_GAP;
          PH_GAP: begin
            frames_left_next  = frames_left - RepW'(1);
            bit_position_next = '0;
            pair_half_next    = 1'b0;
            phase_next        = (frames_left == RepW'(1)) ? PH_IDLE : PH_SYNC;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frames_left  <= '0;
      bit_position <= '0;
      pair_half    <= 1'b0;
      tick_count   <= '0;
      line_level   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      frames_left  <= frames_left_next;
      bit_position <= bit_position_next;
      pair_half    <= pair_half_next;
      tick_count   <= tick_count_next;
      line_level   <= line_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_sender <= held_sender_next;
      held_switch <= held_switch_next;
      held_on     <= held_on_next;
    end
  end

  `ORS_ASSERT(a_idle_no_frames, clk, rst, (phase == PH_IDLE) |-> (frames_left == '0))
  `ORS_ASSERT(a_busy_has_frames, clk, rst, (phase != PH_IDLE) |-> (frames_left != '0))
  `ORS_ASSERT(a_ignored_only_start, clk, rst, res.start_ignored |-> (item.mode == MODE_START))
  `ORS_ASSERT(a_idle_tick_stays, clk, rst,
    (step && (phase == PH_IDLE) && (item.mode == MODE_TICK)) |=> (phase == PH_IDLE))
  // last bit position is kept through the closing pulse and gap
  `ORS_ASSERT_NEVER(a_bitpos_outside_data, clk, rst,
    (bit_position != '0) && ((phase == PH_IDLE) || (phase == PH_SYNC) || (phase == PH_LATCH)))

endmodule
`default_nettype wire

// ===== src/ook_remote_switch_encoder.sv =====
// Result path: a taken item is held in the input reg, and its result item in the result reg.
// Throughput: one item per cycle while results are taken; the whole tick update fits between the two registers.
// Ready follows the result register: a full input stage waits only while a result is held
// and not taken.
// Reset (rst, synchronous, active high): idle, line low, timing registers to defaults.
// Register writes are taken every cycle and land on the following edge.
`timescale 1ns / 1ps
`default_nettype none
module ook_remote_switch_encoder
  import ors_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  ors_item_if.sink     item_in,
  ors_result_if.source result_out,
  ors_cfg_if.sink      cfg
);

  cfg_t    regs;
  item_t   in_data;
  logic    in_full;
  result_t res;
  result_t out_data;
  logic    out_valid;
  logic    step;

  assign step          = in_full && (!out_valid || result_out.ready);
  assign item_in.ready = !in_full || step;

  ors_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ors_frame_core u_core (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .step (step),
    .item (in_data),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_in.valid && item_in.ready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_data <= '{mode: item_in.mode, sender_id: item_in.sender_id,
                   switch_code: item_in.switch_code, turn_on: item_in.turn_on};
    end
    if (step) begin
      out_data <= res;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.pin_level     = out_data.pin_level;
  assign result_out.busy_res      = out_data.busy_res;
  assign result_out.start_ignored = out_data.start_ignored;

endmodule
`default_nettype wire
